@@ rtl/lcss_pkg.sv @@
package lcss_pkg;

    localparam int ROLE_W         = 8;
    localparam int BYTES_W        = 48;
    localparam int KIND_W         = 2;
    localparam int TARGET_W       = 2;
    localparam int STATUS_W       = 3;
    localparam int CHOSEN_W       = 2;
    localparam int CARDS_W        = 3;
    localparam int CAP_REGS       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int S_TDATA_W      = 64;
    localparam int M_TDATA_W      = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int DEF_MAX_CARDS  = 4;
    localparam int DEF_STAMP_BITS = 32;

    // request kinds as they arrive on s_tuser
    localparam logic [KIND_W-1:0] KIND_PLACE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOAD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CARDS_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP0          = 3'd1;

    typedef enum logic [1:0] {
        OP_PLACE,
        OP_LOAD,
        OP_UNLOAD,
        OP_NOP
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_WARM_HIT = 3'd0,
        ST_FITS     = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_NO_CARDS = 3'd3,
        ST_ACK      = 3'd4,
        ST_BAD_CARD = 3'd5
    } status_t;

    typedef struct packed {
        op_t                  op;
        logic [ROLE_W-1:0]    role;
        logic [BYTES_W-1:0]   bytes;
        logic [TARGET_W-1:0]  target;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [CHOSEN_W-1:0]  chosen;
        logic                 dvalid;
        logic [ROLE_W-1:0]    drole;
    } result_t;

    typedef struct packed {
        logic [CARDS_W-1:0]                cards_present;
        logic [CAP_REGS-1:0][BYTES_W-1:0]  cap;
    } cfg_t;

endpackage

@@ rtl/lcss_front.sv @@
module lcss_front
    import lcss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic vld_reg;
    logic vld_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic push;

    assign s_tready  = !vld_reg || cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign push      = vld_reg && cmd_ready;
    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.role   = s_tdata[ROLE_W-1:0];
        cmd_next.bytes  = s_tdata[ROLE_W+BYTES_W-1:ROLE_W];
        cmd_next.target = s_tdata[ROLE_W+BYTES_W+TARGET_W-1:ROLE_W+BYTES_W];
        unique case (s_tuser)
            KIND_PLACE:  cmd_next.op = OP_PLACE;
            KIND_LOAD:   cmd_next.op = OP_LOAD;
            KIND_UNLOAD: cmd_next.op = OP_UNLOAD;
            default:     cmd_next.op = OP_NOP;
        endcase
        if (accept) begin
            vld_next = 1'b1;
        end else if (push) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ rtl/lcss_queue.sv @@
module lcss_queue
    import lcss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_pop,
    output cmd_t rd_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != CNTW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

@@ rtl/lcss_back.sv @@
module lcss_back
    import lcss_pkg::*;
#(
    parameter int MAX_CARDS  = DEF_MAX_CARDS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam int CIW   = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
    localparam int CW    = (CIW > CHOSEN_W) ? CIW : CHOSEN_W;
    localparam int TW    = (CIW > TARGET_W) ? CIW : TARGET_W;
    localparam int NW    = ($clog2(MAX_CARDS + 1) > CARDS_W) ? $clog2(MAX_CARDS + 1) : CARDS_W;
    localparam int CAP_N = (MAX_CARDS < CAP_REGS) ? MAX_CARDS : CAP_REGS;

    typedef logic [MAX_CARDS-1:0]                 mask_t;
    typedef logic [MAX_CARDS-1:0][STAMP_BITS-1:0] stamps_t;

    mask_t                           busy_reg;
    mask_t                           busy_next;
    logic [MAX_CARDS-1:0][ROLE_W-1:0] role_reg;
    logic [MAX_CARDS-1:0][ROLE_W-1:0] role_next;
    stamps_t                         stamp_reg;
    stamps_t                         stamp_next;
    logic [STAMP_BITS-1:0]           counter_reg;
    logic [STAMP_BITS-1:0]           counter_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    result_t                         result_reg;
    result_t                         result_next;

    logic [NW-1:0]      n;
    mask_t              present;
    mask_t              match;
    mask_t              hit;
    mask_t              warm_oh;
    mask_t              idle_cand;
    mask_t              cand;
    mask_t              pick_oh;
    mask_t              tgt_oh;
    mask_t              write_oh;
    mask_t              clear_mask;
    logic [CIW-1:0]     warm_idx;
    logic [CIW-1:0]     pick_idx;
    logic [CW-1:0]      warm_ext;
    logic [CW-1:0]      pick_ext;
    logic [BYTES_W-1:0] cap_sel;
    logic [ROLE_W-1:0]  drole_sel;
    logic               fits;
    logic               bad_target;

    // oldest stamp among the candidates, lowest index on ties
    function automatic mask_t oldest(input mask_t cnd, input stamps_t st);
        mask_t oh;
        logic  win;
        oh = '0;
        for (int i = 0; i < MAX_CARDS; i++) begin
            win = cnd[i];
            for (int j = 0; j < MAX_CARDS; j++) begin
                if (j != i && cnd[j]) begin
                    if (j < i) begin
                        win = win && (st[i] < st[j]);
                    end else begin
                        win = win && (st[i] <= st[j]);
                    end
                end
            end
            oh[i] = win;
        end
        return oh;
    endfunction

    always_comb begin
        n = (NW'(cfg.cards_present) > NW'(MAX_CARDS)) ?
            NW'(MAX_CARDS) : NW'(cfg.cards_present);
        bad_target = (NW'(q_cmd.target) >= n);
        for (int c = 0; c < MAX_CARDS; c++) begin
            present[c] = (NW'(c) < n);
            match[c]   = busy_reg[c] && (role_reg[c] == q_cmd.role);
            tgt_oh[c]  = (TW'(c) == TW'(q_cmd.target));
        end
        hit       = present & match;
        warm_oh   = hit & (~hit + 1'b1);
        idle_cand = present & ~busy_reg;
        cand      = (|idle_cand) ? idle_cand : present;
        pick_oh   = oldest(cand, stamp_reg);

        warm_idx  = '0;
        pick_idx  = '0;
        drole_sel = '0;
        for (int c = 0; c < MAX_CARDS; c++) begin
            if (warm_oh[c]) begin
                warm_idx = warm_idx | CIW'(c);
            end
            if (pick_oh[c]) begin
                pick_idx  = pick_idx | CIW'(c);
                drole_sel = drole_sel | role_reg[c];
            end
        end
        warm_ext = CW'(warm_idx);
        pick_ext = CW'(pick_idx);

        // cards beyond the capacity registers read as unknown size
        cap_sel = '0;
        for (int c = 0; c < CAP_N; c++) begin
            if (pick_oh[c]) begin
                cap_sel = cap_sel | cfg.cap[c];
            end
        end
        fits = (cap_sel == '0) || (q_cmd.bytes <= cap_sel);
    end

    always_comb begin
        q_pop        = q_valid && (!m_valid_reg || m_ready);
        m_valid_next = q_pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        result_next.status = ST_ACK;
        result_next.chosen = '0;
        result_next.dvalid = 1'b0;
        result_next.drole  = '0;
        write_oh           = '0;
        clear_mask         = '0;

        unique case (q_cmd.op)
            OP_PLACE: begin
                if (n == '0) begin
                    result_next.status = ST_NO_CARDS;
                end else if (|warm_oh) begin
                    result_next.status = ST_WARM_HIT;
                    result_next.chosen = warm_ext[CHOSEN_W-1:0];
                end else begin
                    write_oh           = pick_oh;
                    result_next.status = fits ? ST_FITS : ST_OVERFLOW;
                    result_next.chosen = pick_ext[CHOSEN_W-1:0];
                    if (!(|idle_cand)) begin
                        result_next.dvalid = 1'b1;
                        result_next.drole  = drole_sel;
                    end
                end
            end
            OP_LOAD: begin
                if (bad_target) begin
                    result_next.status = ST_BAD_CARD;
                end else begin
                    clear_mask = match & ~tgt_oh;
                    write_oh   = tgt_oh;
                end
            end
            OP_UNLOAD: begin
                clear_mask = match;
            end
            OP_NOP: begin
            end
        endcase

        busy_next    = busy_reg;
        role_next    = role_reg;
        stamp_next   = stamp_reg;
        counter_next = counter_reg;
        if (q_pop) begin
            for (int c = 0; c < MAX_CARDS; c++) begin
                if (clear_mask[c]) begin
                    busy_next[c] = 1'b0;
                end
                if (write_oh[c]) begin
                    busy_next[c]  = 1'b1;
                    role_next[c]  = q_cmd.role;
                    stamp_next[c] = counter_reg;
                end
            end
            // stamp counter sticks at all ones
            if ((|write_oh) && (counter_reg != '1)) begin
                counter_next = counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= '0;
            role_reg    <= '0;
            stamp_reg   <= '0;
            counter_reg <= STAMP_BITS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            role_reg    <= role_next;
            stamp_reg   <= stamp_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

@@ rtl/lru_card_slot_scheduler.sv @@
// lru card slot scheduler
// keeps one slot per card (busy bit, resident role, touch stamp) and answers
// place requests, load notes and unload notes, one result per request.
// input channel s_*: s_tuser carries the request kind, s_tdata the role,
// model size and target card. result channel m_*: status, chosen card and
// any displaced role. capacities and the card count are set through the
// cfg_we / cfg_index / cfg_wdata write port; the user must set them only
// while no request is in flight, as the block itself does not enforce it.
// path: input register, queue, execute stage with output register.
// throughput: one request per cycle while m_tready stays high; the execute stage compares all slots
// in parallel and updates them in the same cycle, so back-to-back requests
// see each other's effect without stalling.
// a two-entry queue separates the input stage from the execute stage: while
// m_tready is low the queue and input register keep taking requests until
// full, then s_tready drops. nothing is lost or repeated.
// reset (aresetn low, synchronous) idles every card, clears stamps and
// configuration, and sets the stamp counter to one.
module lru_card_slot_scheduler
    import lcss_pkg::*;
#(
    parameter int MAX_CARDS  = DEF_MAX_CARDS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // role_id[7:0], size_bytes[55:8], target_card[57:56], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], chosen_card[4:3], evicted_valid[5], evicted_role[13:6], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    front_valid;
    logic    queue_ready;
    cmd_t    front_cmd;
    logic    queue_valid;
    logic    queue_pop;
    cmd_t    queue_cmd;
    result_t result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            if (cfg_index == REG_CARDS_PRESENT) begin
                cfg_next.cards_present = cfg_wdata[CARDS_W-1:0];
            end
            for (int c = 0; c < CAP_REGS; c++) begin
                if (cfg_index == (REG_CAP0 + CFG_IDX_W'(c))) begin
                    cfg_next.cap[c] = cfg_wdata[BYTES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (queue_ready),
        .cmd       (front_cmd)
    );

    lcss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (queue_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_pop   (queue_pop),
        .rd_cmd   (queue_cmd)
    );

    lcss_back #(
        .MAX_CARDS  (MAX_CARDS),
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (queue_valid),
        .q_cmd    (queue_cmd),
        .q_pop    (queue_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {2'b00, result.drole, result.dvalid, result.chosen, result.status};

    // notes and refused placements never name a card or a displaced role
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_ACK || m_tdata[2:0] == ST_BAD_CARD ||
                     m_tdata[2:0] == ST_NO_CARDS)
        |-> (m_tdata[4:3] == 2'b00) && !m_tdata[5] && (m_tdata[13:6] == '0))
        else $error("note result carries placement fields");

    // an eviction only comes from a placement that took a new card
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5]
        |-> (m_tdata[2:0] == ST_FITS || m_tdata[2:0] == ST_OVERFLOW))
        else $error("displaced role reported outside a placement");

    // a warm hit reuses the card and evicts nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_WARM_HIT) |-> !m_tdata[5] && (m_tdata[13:6] == '0))
        else $error("warm hit reports an eviction");

endmodule
